// File: hdl/section_timing_profiler_macros.svh
// Assertion macros for the section timing profiler checker.
// Depends on nothing; included by the checker file.
`ifndef SECTION_TIMING_PROFILER_MACROS_SVH
`define SECTION_TIMING_PROFILER_MACROS_SVH

// same-cycle implication
`define STP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/stp_pkg.sv
// Package for the section timing profiler: sizes, table entry layout, codes.
// No dependencies; used by section_timing_profiler, stp_checker and the dv files.
`timescale 1ns / 1ps

package stp_pkg;

    localparam int NUM_SECTIONS = 256;
    localparam int TICK_WIDTH   = 64;
    localparam int IDX_W        = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
    localparam int ID_W         = 8;
    localparam int SUM_W        = 64;
    localparam int CALLS_W      = 16;
    localparam int FRAMES_W     = 32;
    localparam int DCNT_W       = $clog2(SUM_W);

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_END   = 2'd1,
        MODE_CLOSE = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [TICK_WIDTH-1:0] stamp;
        logic [SUM_W-1:0]      frame_sum;
        logic [CALLS_W-1:0]    frame_calls;
        logic [SUM_W-1:0]      total_sum;
        logic [FRAMES_W-1:0]   frame_total;
    } t_entry;

endpackage

// File: hdl/section_timing_profiler.sv
// Section timing profiler top level: per-section table in one synchronous RAM,
// read-modify-write sequencer and a bit-serial divider for averages.
// Depends on stp_pkg.
`timescale 1ns / 1ps

// Input channel (i_in_valid / o_in_stall) takes one word: mode, section id and
// timestamp. Start stores the stamp, end adds the elapsed ticks to the frame
// sum, close folds the frame into the running total and reports the average.
// Every input word yields exactly one output word (o_out_valid / i_out_stall).
// Start, end, and a close with no frames: the table read cycle and the
// write-back cycle on the single RAM port pair.
// Close that reports: the same read and write-back, then the divider retiring
// one quotient bit per cycle, then the hand-over of the result.
// One word is in flight at a time; the next is taken once the previous
// result sits in the output register, even if it is still stalled there.
// A stalled output word holds; a new result then waits in the block, which
// keeps o_in_stall high until the output register frees up.
// Reset: the table is swept to zero, one entry per cycle, over all NUM_SECTIONS
// (256) entries after reset releases; o_in_stall stays high meanwhile.
// Ids at or above NUM_SECTIONS and mode 3 leave the table untouched and
// report nothing.
module section_timing_profiler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_mode,
    input  logic [stp_pkg::ID_W-1:0]       i_section_id,
    input  logic [63:0]                    i_timestamp,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_report_valid,
    output logic [stp_pkg::ID_W-1:0]       o_report_id,
    output logic [stp_pkg::SUM_W-1:0]      o_average_ticks,
    output logic [stp_pkg::FRAMES_W-1:0]   o_frames_counted
);
    import stp_pkg::*;

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_SECTIONS - 1);
    localparam logic [DCNT_W-1:0] LAST_STEP = DCNT_W'(SUM_W - 1);

    t_state r_state, n_state;

    t_entry r_mem [NUM_SECTIONS];
    t_entry r_rd;

    logic [IDX_W-1:0]      r_clr;
    logic [1:0]            r_mode;
    logic [ID_W-1:0]       r_id;
    logic [TICK_WIDTH-1:0] r_ts;
    logic                  r_ok;

    logic [SUM_W-1:0]      r_quo;
    logic [FRAMES_W-1:0]   r_rem;
    logic [FRAMES_W-1:0]   r_div;
    logic [DCNT_W-1:0]     r_cnt;

    logic                  r_res_rv;
    logic [FRAMES_W-1:0]   r_res_frames;
    logic [SUM_W-1:0]      r_res_avg;

    logic                  r_o_valid;
    logic                  r_o_rv;
    logic [ID_W-1:0]       r_o_id;
    logic [SUM_W-1:0]      r_o_avg;
    logic [FRAMES_W-1:0]   r_o_frames;

    logic                  mem_we, mem_re;
    logic [IDX_W-1:0]      mem_wa, mem_ra;
    t_entry                mem_wd, upd;
    logic [TICK_WIDTH-1:0] elapsed;
    logic                  had_calls, rep, wr_ok;
    logic                  out_free, out_load, out_direct, div_load, div_step, rmw;
    logic [FRAMES_W:0]     rem_sh, diff;
    logic [SUM_W-1:0]      quo_next;
    logic [FRAMES_W-1:0]   rem_next;

    assign out_free   = !r_o_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign rmw        = (r_state == ST_RMW);

    // entry update
    always_comb begin
        upd       = r_rd;
        elapsed   = r_ts - r_rd.stamp;
        had_calls = (r_rd.frame_calls != '0);
        wr_ok     = 1'b0;
        rep       = 1'b0;
        unique case (r_mode)
            MODE_START: begin
                upd.stamp = r_ts;
                wr_ok     = r_ok;
            end
            MODE_END: begin
                upd.frame_sum = r_rd.frame_sum + SUM_W'(elapsed);
                if (r_rd.frame_calls != {CALLS_W{1'b1}}) begin
                    upd.frame_calls = r_rd.frame_calls + CALLS_W'(1);
                end
                wr_ok = r_ok;
            end
            MODE_CLOSE: begin
                if (had_calls) begin
                    upd.total_sum   = r_rd.total_sum + r_rd.frame_sum;
                    upd.frame_sum   = '0;
                    upd.frame_calls = '0;
                    if (r_rd.frame_total != {FRAMES_W{1'b1}}) begin
                        upd.frame_total = r_rd.frame_total + FRAMES_W'(1);
                    end
                end
                wr_ok = r_ok;
                rep   = r_ok && (upd.frame_total != '0);
            end
            default: begin
                wr_ok = 1'b0;
            end
        endcase
    end

    // restoring divider step
    always_comb begin
        rem_sh   = {r_rem, r_quo[SUM_W-1]};
        diff     = rem_sh - {1'b0, r_div};
        rem_next = diff[FRAMES_W] ? rem_sh[FRAMES_W-1:0] : diff[FRAMES_W-1:0];
        quo_next = {r_quo[SUM_W-2:0], !diff[FRAMES_W]};
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        mem_we     = 1'b0;
        mem_wa     = IDX_W'(r_id);
        mem_wd     = upd;
        mem_re     = 1'b0;
        mem_ra     = IDX_W'(i_section_id);
        out_load   = 1'b0;
        out_direct = 1'b0;
        div_load   = 1'b0;
        div_step   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
                if (r_clr == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    mem_re  = 1'b1;
                    n_state = ST_RMW;
                end
            end
            ST_RMW: begin
                mem_we = wr_ok;
                if (rep) begin
                    div_load = 1'b1;
                    n_state  = ST_DIV;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    out_direct = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_DIV: begin
                div_step = 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + IDX_W'(1);
            end
        end
    end

    // table RAM
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_mode <= i_mode;
            r_id   <= i_section_id;
            r_ts   <= i_timestamp[TICK_WIDTH-1:0];
            r_ok   <= (32'(i_section_id) < 32'(NUM_SECTIONS));
        end
    end

    // divider and pending result
    always_ff @(posedge i_clk) begin
        if (rmw) begin
            r_res_rv     <= rep;
            r_res_frames <= rep ? upd.frame_total : '0;
            r_res_avg    <= '0;
        end
        if (div_load) begin
            r_quo <= upd.total_sum;
            r_rem <= '0;
            r_div <= upd.frame_total;
            r_cnt <= '0;
        end else if (div_step) begin
            r_quo <= quo_next;
            r_rem <= rem_next;
            r_cnt <= r_cnt + DCNT_W'(1);
            if (r_cnt == LAST_STEP) begin
                r_res_avg <= quo_next;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_id <= r_id;
            if (out_direct) begin
                r_o_rv     <= 1'b0;
                r_o_avg    <= '0;
                r_o_frames <= '0;
            end else begin
                r_o_rv     <= r_res_rv;
                r_o_avg    <= r_res_avg;
                r_o_frames <= r_res_frames;
            end
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_report_valid   = r_o_rv;
    assign o_report_id      = r_o_id;
    assign o_average_ticks  = r_o_avg;
    assign o_frames_counted = r_o_frames;

endmodule

// File: hdl/stp_checker.sv
// Port-level checks for the section timing profiler, bound to the top level.
// Depends on stp_pkg and section_timing_profiler_macros.svh.
`timescale 1ns / 1ps
`include "section_timing_profiler_macros.svh"

module stp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  logic                           o_report_valid,
    input  logic [stp_pkg::ID_W-1:0]       o_report_id,
    input  logic [stp_pkg::SUM_W-1:0]      o_average_ticks,
    input  logic [stp_pkg::FRAMES_W-1:0]   o_frames_counted
);
    import stp_pkg::*;

    `STP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_report_valid) && $stable(o_report_id) && $stable(o_average_ticks) && $stable(o_frames_counted), "stalled output word changed")
    `STP_ASSERT_IMP(a_report_frames, i_clk, i_rst_n, o_out_valid && o_report_valid, o_frames_counted != '0, "report with zero frame count")
    `STP_ASSERT_IMP(a_quiet_zero, i_clk, i_rst_n, o_out_valid && !o_report_valid, (o_average_ticks == '0) && (o_frames_counted == '0), "non-report word carries data")

endmodule

bind section_timing_profiler stp_checker u_stp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_report_valid   (o_report_valid),
    .o_report_id      (o_report_id),
    .o_average_ticks  (o_average_ticks),
    .o_frames_counted (o_frames_counted)
);

// File: dv/stp_average_checker.sv
// Checker for section_timing_profiler: keeps its own copy of the section table,
// predicts one report word per accepted input word and compares in order.
// Depends on stp_pkg.
`timescale 1ns / 1ps

module stp_average_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [1:0]                   i_mode,
    input  logic [stp_pkg::ID_W-1:0]     i_section_id,
    input  logic [63:0]                  i_timestamp,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic                         i_report_valid,
    input  logic [stp_pkg::ID_W-1:0]     i_report_id,
    input  logic [stp_pkg::SUM_W-1:0]    i_average_ticks,
    input  logic [stp_pkg::FRAMES_W-1:0] i_frames_counted,
    output int                           o_fail_count,
    output int                           o_outstanding
);
    import stp_pkg::*;

    typedef struct packed {
        logic                rvalid;
        logic [ID_W-1:0]     id;
        logic [SUM_W-1:0]    avg;
        logic [FRAMES_W-1:0] frames;
    } t_report;

    localparam logic [63:0]         TICK_MASK  = {64{1'b1}} >> (64 - TICK_WIDTH);
    localparam logic [CALLS_W-1:0]  CALLS_SAT  = '1;
    localparam logic [FRAMES_W-1:0] FRAMES_SAT = '1;
    localparam int                  SHOW_MAX   = 10;

    logic [63:0]         stamp_mem  [NUM_SECTIONS];
    logic [SUM_W-1:0]    frame_mem  [NUM_SECTIONS];
    logic [CALLS_W-1:0]  calls_mem  [NUM_SECTIONS];
    logic [SUM_W-1:0]    total_mem  [NUM_SECTIONS];
    logic [FRAMES_W-1:0] frames_mem [NUM_SECTIONS];

    t_report report_q[$];
    int      bad_words;

    // applies one input word to the table and returns the report it should give
    function automatic t_report account_word(input logic [1:0] mode,
                                             input logic [ID_W-1:0] sid,
                                             input logic [63:0] ts);
        t_report     r;
        logic [63:0] now;
        int unsigned i;
        r   = '0;
        r.id = sid;
        now = ts & TICK_MASK;
        i   = 32'(sid);
        if (32'(sid) < NUM_SECTIONS) begin
            if (mode == MODE_START) begin
                stamp_mem[i] = now;
            end else if (mode == MODE_END) begin
                frame_mem[i] = frame_mem[i] + ((now - stamp_mem[i]) & TICK_MASK);
                if (calls_mem[i] != CALLS_SAT)
                    calls_mem[i] = calls_mem[i] + CALLS_W'(1);
            end else if (mode == MODE_CLOSE) begin
                if (calls_mem[i] != '0) begin
                    total_mem[i] = total_mem[i] + frame_mem[i];
                    if (frames_mem[i] != FRAMES_SAT)
                        frames_mem[i] = frames_mem[i] + FRAMES_W'(1);
                    frame_mem[i] = '0;
                    calls_mem[i] = '0;
                end
                if (frames_mem[i] != '0) begin
                    r.rvalid = 1'b1;
                    r.frames = frames_mem[i];
                    r.avg    = total_mem[i] / {32'b0, frames_mem[i]};
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_report got;
        t_report want;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SECTIONS; k++) begin
                stamp_mem[k]  = '0;
                frame_mem[k]  = '0;
                calls_mem[k]  = '0;
                total_mem[k]  = '0;
                frames_mem[k] = '0;
            end
            report_q.delete();
            bad_words = 0;
            o_fail_count  <= 0;
            o_outstanding <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_report_valid, i_report_id, i_average_ticks, i_frames_counted};
                if (report_q.size() == 0) begin
                    bad_words++;
                    if (bad_words <= SHOW_MAX)
                        $display("%t: report word for id %0d with none pending",
                                 $realtime, got.id);
                end else begin
                    want = report_q.pop_front();
                    if (got.rvalid !== want.rvalid || got.id !== want.id ||
                        got.avg !== want.avg || got.frames !== want.frames) begin
                        bad_words++;
                        if (bad_words <= SHOW_MAX)
                            $display("%t: mismatch exp %0b/%0d/%0h/%0d got %0b/%0d/%0h/%0d",
                                     $realtime, want.rvalid, want.id, want.avg, want.frames,
                                     got.rvalid, got.id, got.avg, got.frames);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                report_q.push_back(account_word(i_mode, i_section_id, i_timestamp));
            o_outstanding <= report_q.size();
            o_fail_count  <= bad_words;
        end
    end

endmodule

// File: dv/tb_section_timing_profiler.sv
// Testbench top for section_timing_profiler: clock, reset, input words, output
// stalls, watchdog, verdict. Depends on stp_pkg, the DUT and stp_average_checker.
`timescale 1ns / 1ps

module tb_section_timing_profiler;
    import stp_pkg::*;

    localparam int         RESET_CYCLES  = 7;
    localparam int         QUIET_LIMIT   = 4000;
    localparam int         RANDOM_WORDS  = 1400;
    localparam int         SETTLE_CYCLES = 100;
    localparam int         HOT_COUNT     = 8;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [1:0]          i_mode;
    logic [ID_W-1:0]     i_section_id;
    logic [63:0]         i_timestamp;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_report_valid;
    logic [ID_W-1:0]     o_report_id;
    logic [SUM_W-1:0]    o_average_ticks;
    logic [FRAMES_W-1:0] o_frames_counted;

    int              fail_count;
    int              outstanding;
    int              quiet_cycles;
    int              burst_left   = 0;
    int              sent_words   = 0;
    int              stall_style  = 0;
    int              stall_span   = 0;
    logic [63:0]     wall_ticks;
    logic [ID_W-1:0] hot_ids [HOT_COUNT];

    section_timing_profiler dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_section_id     (i_section_id),
        .i_timestamp      (i_timestamp),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_report_valid   (o_report_valid),
        .o_report_id      (o_report_id),
        .o_average_ticks  (o_average_ticks),
        .o_frames_counted (o_frames_counted)
    );

    stp_average_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_section_id     (i_section_id),
        .i_timestamp      (i_timestamp),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_report_valid   (o_report_valid),
        .i_report_id      (o_report_id),
        .i_average_ticks  (o_average_ticks),
        .i_frames_counted (o_frames_counted),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: stretches of free flow, light stalls, heavy stalls and solid blocks
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_span  = $urandom_range(4, 60);
        end else begin
            stall_span--;
        end
        case (stall_style)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 3) != 0)
            return hot_ids[$urandom_range(0, HOT_COUNT - 1)];
        return ID_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [63:0] rand_span();
        case ($urandom_range(0, 9))
            0: return rand64();
            1: return '0;
            default: return 64'($urandom_range(1, 5000));
        endcase
    endfunction

    // one word, in bursts with random gaps in between
    task automatic send_word(input logic [1:0] mode, input logic [ID_W-1:0] sid,
                             input logic [63:0] ts);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_section_id <= sid;
        i_timestamp  <= ts;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
        if (mode != MODE_UNUSED)
            sent_words++;
    endtask

    task automatic drain_reports();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic section_call(input logic [ID_W-1:0] sid);
        send_word(MODE_START, sid, wall_ticks);
        wall_ticks = wall_ticks + rand_span();
        send_word(MODE_END, sid, wall_ticks);
        wall_ticks = wall_ticks + 64'($urandom_range(0, 300));
    endtask

    initial begin : stimulus
        int              random_base;
        int              pick;
        logic [ID_W-1:0] a_id;
        logic [ID_W-1:0] b_id;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_mode       <= MODE_START;
        i_section_id <= '0;
        i_timestamp  <= '0;
        wall_ticks   = 64'hFFFF_FFFF_FFFF_0000;
        hot_ids[0]   = '0;
        hot_ids[1]   = '1;
        for (int k = 2; k < HOT_COUNT; k++)
            hot_ids[k] = ID_W'($urandom_range(0, 255));
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // close with nothing recorded, end without a start, a second frame
        send_word(MODE_CLOSE, 8'd0, rand64());
        send_word(MODE_END, 8'd1, 64'd100);
        send_word(MODE_CLOSE, 8'd1, 64'd0);
        send_word(MODE_START, 8'd1, 64'd10);
        send_word(MODE_END, 8'd1, 64'd40);
        send_word(MODE_CLOSE, 8'd1, '1);
        // tick wrap between start and end
        send_word(MODE_START, 8'd255, '1);
        send_word(MODE_END, 8'd255, 64'd5);
        send_word(MODE_END, 8'd255, 64'd0);
        send_word(MODE_CLOSE, 8'd255, 64'd0);
        // frame sum wraps to zero, then a close with no new calls
        send_word(MODE_START, 8'd2, 64'd0);
        send_word(MODE_END, 8'd2, 64'h8000_0000_0000_0000);
        send_word(MODE_END, 8'd2, 64'h8000_0000_0000_0000);
        send_word(MODE_CLOSE, 8'd2, 64'd0);
        send_word(MODE_CLOSE, 8'd2, '1);
        // unused mode leaves the table alone
        send_word(MODE_UNUSED, 8'd7, '1);
        send_word(MODE_UNUSED, 8'd0, 64'd0);
        send_word(MODE_CLOSE, 8'd7, 64'd0);
        send_word(MODE_END, 8'd4, '1);
        send_word(MODE_CLOSE, 8'd4, 64'd0);
        send_word(MODE_START, 8'd3, 64'h5555_5555_5555_5555);
        send_word(MODE_END, 8'd3, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(MODE_CLOSE, 8'd3, 64'd0);
        send_word(MODE_CLOSE, 8'd128, rand64());
        drain_reports();

        random_base = sent_words;
        while (sent_words - random_base < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                section_call(pick_id());
            end else if (pick < 75) begin
                send_word(MODE_CLOSE, pick_id(), rand64());
            end else if (pick < 80) begin
                foreach (hot_ids[k])
                    send_word(MODE_CLOSE, hot_ids[k], rand64());
            end else if (pick < 90) begin
                send_word(2'($urandom_range(0, 3)), ID_W'($urandom_range(0, 255)), rand64());
            end else if (pick < 95) begin
                send_word($urandom_range(0, 1) ? MODE_START : MODE_END, pick_id(), rand64());
            end else begin
                // nested sections
                a_id = pick_id();
                b_id = pick_id();
                send_word(MODE_START, a_id, wall_ticks);
                wall_ticks = wall_ticks + 64'($urandom_range(1, 500));
                section_call(b_id);
                send_word(MODE_END, a_id, wall_ticks);
            end
            if (sent_words - random_base >= RANDOM_WORDS / 2 && pick == 0)
                drain_reports();
        end

        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/stp_pkg.sv
hdl/section_timing_profiler.sv
hdl/stp_checker.sv
dv/stp_average_checker.sv
dv/tb_section_timing_profiler.sv
